@@ hw/rtl/ewcpg_pkg.sv @@
package ewcpg_pkg;

  localparam int unsigned DATA_W              = 32;
  localparam int unsigned IDX_W               = 12;
  localparam int unsigned KIND_W              = 2;
  localparam int unsigned CFG_IDX_W           = 1;
  localparam int unsigned PARAM_DEPTH_DEFAULT = 4096;
  localparam int unsigned Q_FRAC              = 24;

  localparam logic [DATA_W-1:0] Q_ONE  = 32'h0100_0000;
  localparam logic [DATA_W-1:0] Q_HALF = 32'h0080_0000;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_SNAPSHOT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ZERO       = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACCUMULATE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_APPLY      = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_STRENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCUMULATE_SCALE = 1'd1;

  typedef struct packed {
    logic load;
    logic read;
    logic round_t;
    logic mul_lo;
    logic mul_hi;
    logic acc_add;
    logic finish;
    logic clear;
  } ewcpg_cmd_t;

  typedef struct packed {
    logic needs_mul;
    logic clear_last;
  } ewcpg_sts_t;

endpackage

@@ hw/rtl/ewcpg_ram.sv @@
module ewcpg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ewcpg_ctrl.sv @@
module ewcpg_ctrl import ewcpg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  ewcpg_sts_t sts_i,
  output ewcpg_cmd_t cmd_o,
  output logic       busy_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_MUL1  = 3'd3;
  localparam logic [2:0] ST_MUL2  = 3'd4;
  localparam logic [2:0] ST_MUL3  = 3'd5;
  localparam logic [2:0] ST_MUL4  = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = sts_i.needs_mul ? ST_MUL1 : ST_FIN;
      end
      ST_MUL1: begin
        cmd_o.round_t = 1'b1;
        state_d       = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL3;
      end
      ST_MUL3: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_MUL4;
      end
      ST_MUL4: begin
        cmd_o.acc_add = 1'b1;
        state_d       = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

@@ hw/rtl/ewcpg_dp.sv @@
module ewcpg_dp import ewcpg_pkg::*; #(
  parameter int unsigned PARAM_DEPTH = PARAM_DEPTH_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ewcpg_cmd_t           cmd_i,
  output ewcpg_sts_t           sts_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [IDX_W-1:0]     param_index_i,
  input  logic [DATA_W-1:0]    weight_value_i,
  input  logic [DATA_W-1:0]    grad_value_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output logic                 done_o,
  output logic [DATA_W-1:0]    grad_out_o,
  output logic [DATA_W-1:0]    fisher_out_o
);

  localparam int unsigned AW = $clog2(PARAM_DEPTH);

  // input latches
  logic [KIND_W-1:0] kind_q;
  logic [IDX_W-1:0]  idx_q;
  logic [DATA_W-1:0] weight_q;
  logic [DATA_W-1:0] grad_q;

  // config
  logic [DATA_W-1:0] penalty_q;
  logic [DATA_W-1:0] scale_q;

  // arithmetic
  logic [DATA_W-1:0] fisher_q;
  logic [32:0]       op2_q;
  logic              neg_q;
  logic [64:0]       prod_q;
  logic [39:0]       t_q;
  logic [72:0]       acc_q;

  // results
  logic              done_q;
  logic [DATA_W-1:0] grad_out_q;
  logic [DATA_W-1:0] fisher_out_q;
  logic [AW-1:0]     clr_addr_q;

  // RAM signals
  logic [DATA_W-1:0] anchor_rd, fisher_rd;
  logic              anchor_we, fisher_we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] anchor_wd, fisher_wd;

  logic              in_range, lam_pos;
  logic [DATA_W-1:0] mag, scale_eff;
  logic [32:0]       dx, dm;
  logic [DATA_W-1:0] mul_a;
  logic [32:0]       mul_b;
  logic [64:0]       prod_d;
  logic [48:0]       rnd;
  logic [49:0]       fsum;
  logic [DATA_W-1:0] fsat;
  logic [50:0]       gx, pmx, gsum;
  logic [DATA_W-1:0] gsat;
  logic [DATA_W-1:0] gout_d, fout_d;

  assign in_range  = (32'(idx_q) < 32'(PARAM_DEPTH));
  assign lam_pos   = !penalty_q[DATA_W-1] && (penalty_q != '0);
  assign mag       = grad_q[DATA_W-1] ? (~grad_q + 32'd1) : grad_q;
  assign scale_eff = (scale_q[DATA_W-1] || scale_q == '0) ? Q_ONE : scale_q;

  // exact 33-bit difference against the anchor, split into sign and magnitude
  assign dx = {weight_q[DATA_W-1], weight_q} - {anchor_rd[DATA_W-1], anchor_rd};
  assign dm = dx[32] ? (~dx + 33'd1) : dx;

  assign sts_o.needs_mul  = in_range &&
                            (kind_q == KIND_ACCUMULATE || (kind_q == KIND_APPLY && lam_pos));
  assign sts_o.clear_last = (clr_addr_q == AW'(PARAM_DEPTH - 1));

  // shared 32x33 multiplier
  always_comb begin
    mul_a = t_q[31:0];
    mul_b = op2_q;
    if (cmd_i.read) begin
      if (kind_q == KIND_ACCUMULATE) begin
        mul_a = mag;
        mul_b = {1'b0, mag};
      end else begin
        mul_a = penalty_q;
        mul_b = {1'b0, fisher_rd};
      end
    end else if (cmd_i.mul_hi) begin
      mul_a = {24'd0, t_q[39:32]};
    end
  end

  assign prod_d = mul_a * mul_b;

  assign rnd  = acc_q[72:24];
  assign fsum = 50'(fisher_q) + 50'(rnd);
  assign fsat = (|fsum[49:32]) ? 32'hFFFF_FFFF : fsum[31:0];

  assign gx   = {{19{grad_q[DATA_W-1]}}, grad_q};
  assign pmx  = {2'b00, rnd};
  assign gsum = neg_q ? (gx - pmx) : (gx + pmx);

  always_comb begin
    if (gsum[50:31] == '0 || gsum[50:31] == '1) begin
      gsat = gsum[31:0];
    end else if (gsum[50]) begin
      gsat = 32'h8000_0000;
    end else begin
      gsat = 32'h7FFF_FFFF;
    end
  end

  // result and store update for the finishing request, and the zeroing writes of the clear sweep
  always_comb begin
    gout_d    = grad_q;
    fout_d    = fisher_q;
    anchor_we = 1'b0;
    fisher_we = 1'b0;
    anchor_wd = weight_q;
    fisher_wd = '0;
    waddr     = AW'(idx_q);
    if (cmd_i.clear) begin
      anchor_we = 1'b1;
      fisher_we = 1'b1;
      anchor_wd = '0;
      waddr     = clr_addr_q;
    end else if (cmd_i.finish) begin
      if (!in_range) begin
        fout_d = '0;
      end else begin
        case (kind_q)
          KIND_SNAPSHOT: begin
            anchor_we = 1'b1;
          end
          KIND_ZERO: begin
            fisher_we = 1'b1;
            fout_d    = '0;
          end
          KIND_ACCUMULATE: begin
            fisher_we = 1'b1;
            fisher_wd = fsat;
            fout_d    = fsat;
          end
          KIND_APPLY: begin
            if (lam_pos) begin
              gout_d = gsat;
            end
          end
          default: begin
            gout_d = grad_q;
          end
        endcase
      end
    end
  end

  ewcpg_ram #(
    .WIDTH (DATA_W),
    .DEPTH (PARAM_DEPTH)
  ) u_anchor_ram (
    .clk_i   (clk_i),
    .we_i    (anchor_we),
    .waddr_i (waddr),
    .wdata_i (anchor_wd),
    .re_i    (cmd_i.load),
    .raddr_i (AW'(param_index_i)),
    .rdata_o (anchor_rd)
  );

  ewcpg_ram #(
    .WIDTH (DATA_W),
    .DEPTH (PARAM_DEPTH)
  ) u_fisher_ram (
    .clk_i   (clk_i),
    .we_i    (fisher_we),
    .waddr_i (waddr),
    .wdata_i (fisher_wd),
    .re_i    (cmd_i.load),
    .raddr_i (AW'(param_index_i)),
    .rdata_o (fisher_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      penalty_q  <= '0;
      scale_q    <= Q_ONE;
      done_q     <= 1'b0;
      clr_addr_q <= '0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PENALTY_STRENGTH: penalty_q <= cfg_data_i;
          CFG_ACCUMULATE_SCALE: scale_q   <= cfg_data_i;
          default: begin
            penalty_q <= penalty_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      idx_q    <= param_index_i;
      weight_q <= weight_value_i;
      grad_q   <= grad_value_i;
    end
    if (cmd_i.read) begin
      fisher_q <= fisher_rd;
      neg_q    <= dx[32];
      op2_q    <= (kind_q == KIND_ACCUMULATE) ? {1'b0, scale_eff} : dm;
    end
    if (cmd_i.read || cmd_i.mul_lo || cmd_i.mul_hi) begin
      prod_q <= prod_d;
    end
    if (cmd_i.round_t) begin
      t_q <= 40'((prod_q + 65'(Q_HALF)) >> Q_FRAC);
    end
    // low partial product plus rounding half, then add the high partial product
    if (cmd_i.mul_hi) begin
      acc_q <= 73'(prod_q) + 73'(Q_HALF);
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + {prod_q[40:0], 32'd0};
    end
    if (cmd_i.finish) begin
      grad_out_q   <= gout_d;
      fisher_out_q <= fout_d;
    end
  end

  assign done_o       = done_q;
  assign grad_out_o   = grad_out_q;
  assign fisher_out_o = fisher_out_q;

endmodule

@@ hw/rtl/ewc_penalty_gradient_engine.sv @@
// Elastic weight consolidation engine over a flat parameter space of PARAM_DEPTH
// entries, each holding an anchor and a Fisher value in two RAMs. After reset the
// block sweeps both RAMs to zero, one entry per cycle, and holds busy high until the
// sweep ends; configuration writes are taken at any time (cfg_ready_o is always high)
// but must only change while no request is in flight. A request is taken when start
// is high and busy is low. Snapshot, zero, out-of-range indexes and apply with a
// non-positive penalty strength go from read to finish; accumulate and enabled apply
// also pass the round_t, mul_lo, mul_hi and acc_add steps of the single shared 32x33
// multiplier, which forms the first product and then the two partial products of the
// second. The result appears on grad_out_o and fisher_out_o with done_o high for
// exactly one cycle; there is no way to stall it, so the receiver must take it then.
module ewc_penalty_gradient_engine import ewcpg_pkg::*; #(
  parameter int unsigned PARAM_DEPTH = PARAM_DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [KIND_W-1:0]           kind_i,
  input  logic [IDX_W-1:0]            param_index_i,
  input  logic signed [DATA_W-1:0]    weight_value_i,
  input  logic signed [DATA_W-1:0]    grad_value_i,
  output logic                        done_o,
  output logic signed [DATA_W-1:0]    grad_out_o,
  output logic [DATA_W-1:0]           fisher_out_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [DATA_W-1:0]           cfg_data_i
);

  ewcpg_cmd_t        cmd;
  ewcpg_sts_t        sts;
  logic              busy_int;
  logic [DATA_W-1:0] grad_out;

  assign cfg_ready_o = 1'b1;
  assign busy        = busy_int;
  assign grad_out_o  = grad_out;

  ewcpg_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_int)
  );

  ewcpg_dp #(
    .PARAM_DEPTH (PARAM_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (kind_i),
    .param_index_i  (param_index_i),
    .weight_value_i (weight_value_i),
    .grad_value_i   (grad_value_i),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .grad_out_o     (grad_out),
    .fisher_out_o   (fisher_out_o)
  );

endmodule
